// ===== design/mpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mpp_pkg;

  // default sizes
  localparam int unsigned KERNEL_DIM_DEF   = 3;
  localparam int unsigned CHANNELS_IN_DEF  = 16;
  localparam int unsigned CHANNELS_OUT_DEF = 16;

  // field widths
  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned TAP_W    = 4;
  localparam int unsigned Q15_W    = 16;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned RND_W    = 17;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned RES_W    = 32;
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned CHAN_MAX = 16;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 40'sh80_0000_0000;
  localparam logic [RES_W-1:0]        RES_MAX = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0]        RES_MIN = 32'h8000_0000;
  localparam logic signed [Q15_W-1:0] Q15_MAX = 16'sh7FFF;

  // operation codes carried in tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROD,
    ST_ACC
  } mpp_state_e;

  // control broadcast to the cell row
  typedef struct packed {
    logic load_en;
    logic read_en;
    logic prod_en;
    logic acc_en;
    logic capture;
    logic shift;
  } mpp_ctrl_t;

  // round half up of a Q2.30 product back to Q1.15, 17 bits wide
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + 32'sd16384;
    return t[PROD_W-1:PROD_W-RND_W];
  endfunction

  // clamp the accumulator to 32 bits signed
  function automatic logic [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] v);
    logic [RES_W-1:0] r;
    if (v[ACC_W-1:RES_W-1] == '0 || v[ACC_W-1:RES_W-1] == '1) begin
      r = v[RES_W-1:0];
    end else begin
      r = v[ACC_W-1] ? RES_MIN : RES_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/modulated_patch_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none

// modulated convolution, one output pixel per patch
// input stream (s_axis): tuser selects load (0) or patch element (1), tlast marks
// the final patch element; tdata carries in_chan, tap, out_chan, weight_value,
// sample and modulation
// a load writes one weight word and the block is ready again at once
// a patch element goes through accept, modulate (sample times modulation),
// per-channel weight product and accumulate; the weight multiply and the
// accumulate sit in a row of one cell per output channel
// on a last element each cell captures its saturated sum into a shift line and
// clears its accumulator; results leave from cell 0 one transfer per cycle
// while the receiver is ready, channel 0 first, tlast on the final channel
// output stream (m_axis): tdata holds result_chan and result_value
// the next patch may stream in while results drain; a further last element waits
// in the accumulate step until the previous pixel has fully drained
// a stalled receiver holds the head result and the shift line in place
// reset clears the accumulators and the control; the weight memories are not
// cleared and must be loaded before use
module modulated_patch_projection import mpp_pkg::*; #(
  parameter int unsigned KERNEL_DIM   = KERNEL_DIM_DEF,
  parameter int unsigned CHANNELS_IN  = CHANNELS_IN_DEF,
  parameter int unsigned CHANNELS_OUT = CHANNELS_OUT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // in_chan[3:0], tap[7:4], out_chan[11:8], weight_value[27:12],
  // sample[43:28], modulation[59:44], zero fill[63:60]
  input  wire logic [63:0] s_axis_tdata_i,
  // operation
  input  wire logic        s_axis_tuser_i,
  // last_element
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // result_chan[3:0], result_value[35:4], zero fill[39:36]
  output logic [39:0]      m_axis_tdata_o,
  // result_last
  output logic             m_axis_tlast_o
);

  localparam int unsigned TAP_COUNT  = KERNEL_DIM * KERNEL_DIM;
  localparam int unsigned IN_ACTIVE  = (CHANNELS_IN < CHAN_MAX) ? CHANNELS_IN : CHAN_MAX;
  localparam int unsigned TAP_ACTIVE = (TAP_COUNT < CHAN_MAX) ? TAP_COUNT : CHAN_MAX;
  localparam int unsigned OUT_ACTIVE = (CHANNELS_OUT < CHAN_MAX) ? CHANNELS_OUT : CHAN_MAX;
  localparam int unsigned DEPTH      = IN_ACTIVE * TAP_ACTIVE;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = (OUT_ACTIVE > 1) ? $clog2(OUT_ACTIVE) : 1;

  // input fields
  logic [CHAN_W-1:0]       in_chan;
  logic [TAP_W-1:0]        tap;
  logic [CHAN_W-1:0]       out_chan;
  logic signed [Q15_W-1:0] weight_value;
  logic signed [Q15_W-1:0] sample;
  logic signed [Q15_W-1:0] modulation;

  assign in_chan      = s_axis_tdata_i[3:0];
  assign tap          = s_axis_tdata_i[7:4];
  assign out_chan     = s_axis_tdata_i[11:8];
  assign weight_value = s_axis_tdata_i[27:12];
  assign sample       = s_axis_tdata_i[43:28];
  assign modulation   = s_axis_tdata_i[59:44];

  logic              s_fire;
  logic              m_fire;
  logic              in_ok;
  logic [ROW_W-1:0]  row_w;
  logic [ADDR_W-1:0] addr;

  mpp_state_e state_q, state_d;
  mpp_ctrl_t  ctrl;

  logic signed [Q15_W-1:0]  sample_q;
  logic signed [Q15_W-1:0]  mod_q;
  logic signed [Q15_W-1:0]  ms_q;
  logic signed [PROD_W-1:0] ms_mult;
  logic signed [RND_W-1:0]  ms_rnd;
  logic                     in_ok_q;
  logic                     last_q;

  // drain of the result shift line
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             start_drain;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  // element address within each cell's weight memory
  assign in_ok = ({1'b0, in_chan} < (CHAN_W+1)'(IN_ACTIVE)) &&
                 ({1'b0, tap} < (TAP_W+1)'(TAP_ACTIVE));
  assign row_w = ROW_W'(in_chan) * ROW_W'(TAP_ACTIVE) + ROW_W'(tap);
  assign addr  = row_w[ADDR_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    ctrl         = '0;
    ctrl.shift   = m_fire;
    start_drain  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i == OP_PATCH) begin
            ctrl.read_en = 1'b1;
            state_d      = ST_MOD;
          end else begin
            ctrl.load_en = in_ok;
          end
        end
      end
      ST_MOD: begin
        state_d = ST_PROD;
      end
      ST_PROD: begin
        ctrl.prod_en = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        // a last element waits until the previous pixel has left the shift line
        if (!(last_q && busy_q)) begin
          ctrl.acc_en  = in_ok_q;
          ctrl.capture = last_q;
          start_drain  = last_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // patch element operands
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser_i == OP_PATCH) begin
      sample_q <= sample;
      mod_q    <= modulation;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ok_q <= 1'b0;
      last_q  <= 1'b0;
    end else if (s_fire && s_axis_tuser_i == OP_PATCH) begin
      in_ok_q <= in_ok;
      last_q  <= s_axis_tlast_i;
    end
  end

  // modulated sample, rounded to Q1.15; only -1 times -1 overflows
  assign ms_mult = sample_q * mod_q;
  assign ms_rnd  = round_q15(ms_mult);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MOD) begin
      ms_q <= (ms_rnd[RND_W-1] == 1'b0 && ms_rnd[Q15_W-1] == 1'b1) ? Q15_MAX
                                                                   : ms_rnd[Q15_W-1:0];
    end
  end

  // one MAC cell per output channel, results chained toward cell 0
  logic [RES_W-1:0] chain_w [OUT_ACTIVE+1];

  assign chain_w[OUT_ACTIVE] = '0;

  for (genvar i = 0; i < OUT_ACTIVE; i++) begin : g_cell
    mpp_cell #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .CELL_ID(i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .wr_chan_i   (out_chan),
      .addr_i      (addr),
      .wr_data_i   (weight_value),
      .mod_sample_i(ms_q),
      .shift_i     (chain_w[i+1]),
      .shift_o     (chain_w[i])
    );
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_drain) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (m_fire) begin
      if (cnt_q == CNT_W'(OUT_ACTIVE - 1)) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = (cnt_q == CNT_W'(OUT_ACTIVE - 1));
  assign m_axis_tdata_o  = {4'b0000, chain_w[0], CHAN_W'(cnt_q)};

endmodule

`default_nettype wire

// ===== design/mpp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpp_cell import mpp_pkg::*; #(
  parameter int unsigned DEPTH   = 144,
  parameter int unsigned ADDR_W  = 8,
  parameter int unsigned CELL_ID = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire mpp_ctrl_t                ctrl_i,
  input  wire logic [CHAN_W-1:0]        wr_chan_i,
  input  wire logic [ADDR_W-1:0]        addr_i,
  input  wire logic signed [Q15_W-1:0]  wr_data_i,
  input  wire logic signed [Q15_W-1:0]  mod_sample_i,
  input  wire logic [RES_W-1:0]         shift_i,
  output logic [RES_W-1:0]              shift_o
);

  logic signed [Q15_W-1:0]  weight_mem_q [DEPTH];
  logic signed [Q15_W-1:0]  weight_q;
  logic signed [RND_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic [RES_W-1:0]         out_q;
  logic signed [PROD_W-1:0] mult_w;
  logic signed [ACC_W:0]    sum_w;
  logic signed [ACC_W-1:0]  sum_sat;

  // this channel's weights, one row per input channel and tap
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_en && wr_chan_i == CHAN_W'(CELL_ID)) begin
      weight_mem_q[addr_i] <= wr_data_i;
    end
    if (ctrl_i.read_en) begin
      weight_q <= weight_mem_q[addr_i];
    end
  end

  assign mult_w = mod_sample_i * weight_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      prod_q <= round_q15(mult_w);
    end
  end

  always_comb begin
    sum_w = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_q);
    if (sum_w[ACC_W] != sum_w[ACC_W-1]) begin
      sum_sat = sum_w[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_w[ACC_W-1:0];
    end
    acc_d = ctrl_i.acc_en ? sum_sat : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.capture) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  // result shift line toward cell 0
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      out_q <= sat_res(acc_d);
    end else if (ctrl_i.shift) begin
      out_q <= shift_i;
    end
  end

  assign shift_o = out_q;

endmodule

`default_nettype wire

// ===== design/mpp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpp_checker import mpp_pkg::*; #(
  parameter int unsigned CHANNELS_OUT = CHANNELS_OUT_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  localparam int unsigned OUT_ACTIVE = (CHANNELS_OUT < CHAN_MAX) ? CHANNELS_OUT : CHAN_MAX;

  logic m_fire;
  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // every pixel starts at channel 0
  a_first_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> m_axis_tdata_o[3:0] == 4'd0)
    else $error("pixel does not start at channel 0");

  // channels follow without gaps inside a pixel
  a_next_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire && !m_axis_tlast_o |=>
      m_axis_tvalid_o && m_axis_tdata_o[3:0] == $past(m_axis_tdata_o[3:0]) + 4'd1)
    else $error("channel sequence broken");

  // last mark exactly on the final channel
  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      m_axis_tlast_o == (m_axis_tdata_o[3:0] == CHAN_W'(OUT_ACTIVE - 1)))
    else $error("last mark on wrong channel");

endmodule

bind modulated_patch_projection mpp_checker #(
  .CHANNELS_OUT(CHANNELS_OUT)
) u_mpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o)
);

`default_nettype wire
